FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = ROWS * COLS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLS + 1);

    localparam int IDX_W  = 11;
    localparam int CPOS_W = 11;
    localparam int LIN_W  = ($clog2(CELLS + 1) > IDX_W) ? $clog2(CELLS + 1) : IDX_W;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h07;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = PADDR_W - 2;
    localparam logic [REG_W-1:0] REG_TEXT_ATTR = 1'b0;

endpackage

FILE: hw/rtl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/text_console_writer.sv
// Text console writer: a ROWS x COLS store of character/attribute cells with a
// cursor. After reset the block runs a clearing pass over every cell of the
// store, accepting no item; register writes are taken at any time. Each item
// then passes through the store: a newline goes straight to its response,
// while a read or an ordinary put first takes a read or a write step. A put
// that scrolls copies every row up one cell at a time through the store's one
// read and one write port, then blanks the last row before its own write. The
// block takes no new item until the result of the one before sits in the
// output register; a stalled result holds the block in its last step.
module text_console_writer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]           paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]           pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [tcw_pkg::CHAR_W-1:0]            char_code,
    input  logic [tcw_pkg::IDX_W-1:0]             cell_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tcw_pkg::CPOS_W-1:0]            cursor_pos,
    output logic [tcw_pkg::CHAR_W-1:0]            read_char,
    output logic [tcw_pkg::ATTR_W-1:0]            read_attr,
    output logic                                  scrolled
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_RD     = 8'b0000_0100,
        ST_SCR_RD = 8'b0000_1000,
        ST_SCR_WR = 8'b0001_0000,
        ST_FILL   = 8'b0010_0000,
        ST_PUT    = 8'b0100_0000,
        ST_RESP   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::LIN_W-1:0]  cursor_reg, cursor_next;
    logic [tcw_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic [tcw_pkg::CHAR_W-1:0] ch_reg, ch_next;
    logic                       in_range_reg, in_range_next;

    logic [tcw_pkg::CHAR_W-1:0] res_char_reg, res_char_next;
    logic [tcw_pkg::ATTR_W-1:0] res_attr_reg, res_attr_next;
    logic                       res_scr_reg, res_scr_next;

    logic                       out_valid_reg, out_valid_next;
    logic [tcw_pkg::CPOS_W-1:0] cursor_pos_reg, cursor_pos_next;
    logic [tcw_pkg::CHAR_W-1:0] read_char_reg, read_char_next;
    logic [tcw_pkg::ATTR_W-1:0] read_attr_reg, read_attr_next;
    logic                       scrolled_reg, scrolled_next;

    logic                       ram_we;
    logic [tcw_pkg::ADDR_W-1:0] ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic [tcw_pkg::ADDR_W-1:0] ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    logic                       cfg_wr;
    logic [tcw_pkg::LIN_W-1:0]  idx_lin;
    logic [tcw_pkg::LIN_W-1:0]  row_base;
    logic [tcw_pkg::LIN_W-1:0]  put_lin;
    logic [tcw_pkg::COL_W-1:0]  wrap_col;
    logic [tcw_pkg::ROW_W-1:0]  wrap_row;
    logic                       in_acc;
    logic                       out_free;

    tcw_ram #(
        .WIDTH(tcw_pkg::CELL_W),
        .DEPTH(tcw_pkg::CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[tcw_pkg::PADDR_W-1:2] == tcw_pkg::REG_TEXT_ATTR);

    always_comb
    begin
        if (paddr[tcw_pkg::PADDR_W-1:2] == tcw_pkg::REG_TEXT_ATTR)
        begin
            prdata = tcw_pkg::PDATA_W'(attr_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign read_char  = read_char_reg;
    assign read_attr  = read_attr_reg;
    assign scrolled   = scrolled_reg;

    assign idx_lin  = tcw_pkg::LIN_W'(cell_index);
    assign row_base = tcw_pkg::LIN_W'(row_reg) * tcw_pkg::LIN_W'(tcw_pkg::COLS);
    assign put_lin  = row_base + tcw_pkg::LIN_W'(col_reg);

    // column wrap at row end
    always_comb
    begin
        wrap_col = col_reg;
        wrap_row = row_reg;
        if (col_reg >= tcw_pkg::COL_W'(tcw_pkg::COLS))
        begin
            wrap_col = '0;
            if (row_reg < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
            begin
                wrap_row = row_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cursor_next     = cursor_reg;
        cnt_next        = cnt_reg;
        attr_next       = attr_reg;
        ch_next         = ch_reg;
        in_range_next   = in_range_reg;
        res_char_next   = res_char_reg;
        res_attr_next   = res_attr_reg;
        res_scr_next    = res_scr_reg;
        out_valid_next  = out_valid_reg;
        cursor_pos_next = cursor_pos_reg;
        read_char_next  = read_char_reg;
        read_attr_next  = read_attr_reg;
        scrolled_next   = scrolled_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg;
        ram_wdata       = {tcw_pkg::BLANK_ATTR, tcw_pkg::SPACE_CHAR};
        ram_raddr       = idx_lin[tcw_pkg::ADDR_W-1:0];

        if (cfg_wr)
        begin
            attr_next = pwdata[tcw_pkg::ATTR_W-1:0];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    res_scr_next  = 1'b0;
                    if (command == tcw_pkg::CMD_READ)
                    begin
                        in_range_next = (idx_lin < tcw_pkg::LIN_W'(tcw_pkg::CELLS));
                        state_next    = ST_RD;
                    end
                    else if (char_code == tcw_pkg::NEWLINE_CHAR)
                    begin
                        if (row_reg < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                        begin
                            row_next = row_reg + 1'b1;
                        end
                        col_next   = '0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ch_next  = char_code;
                        col_next = wrap_col;
                        row_next = wrap_row;
                        if (wrap_row >= tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                        begin
                            row_next     = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                            res_scr_next = 1'b1;
                            cnt_next     = '0;
                            state_next   = ST_SCR_RD;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                end
            end
            ST_RD:
            begin
                if (in_range_reg)
                begin
                    res_char_next = ram_rdata[tcw_pkg::CHAR_W-1:0];
                    res_attr_next = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                end
                state_next = ST_RESP;
            end
            ST_SCR_RD:
            begin
                // fetch the cell one row below
                ram_raddr  = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS - 1))
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_SCR_RD;
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = {attr_reg, tcw_pkg::SPACE_CHAR};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = put_lin[tcw_pkg::ADDR_W-1:0];
                ram_wdata   = {attr_reg, ch_reg};
                col_next    = col_reg + 1'b1;
                cursor_next = put_lin + 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    cursor_pos_next = cursor_reg[tcw_pkg::CPOS_W-1:0];
                    read_char_next  = res_char_reg;
                    read_attr_next  = res_attr_reg;
                    scrolled_next   = res_scr_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            cursor_reg    <= '0;
            cnt_reg       <= '0;
            attr_reg      <= tcw_pkg::BLANK_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cursor_reg    <= cursor_next;
            cnt_reg       <= cnt_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        in_range_reg   <= in_range_next;
        res_char_reg   <= res_char_next;
        res_attr_reg   <= res_attr_next;
        res_scr_reg    <= res_scr_next;
        cursor_pos_reg <= cursor_pos_next;
        read_char_reg  <= read_char_next;
        read_attr_reg  <= read_attr_next;
        scrolled_reg   <= scrolled_next;
    end

    // the store is never written while waiting for an item
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("store written while idle");

    // cursor stays within its bounds
    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= tcw_pkg::COL_W'(tcw_pkg::COLS))
        && (row_reg <= tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
        else $error("cursor out of bounds");

    // a character write lands inside the screen
    a_put_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT) |-> (row_reg < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
        && (col_reg < tcw_pkg::COL_W'(tcw_pkg::COLS)))
        else $error("put outside screen");

    // blanking the last row happens with the cursor on the last row
    a_fill_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
        && res_scr_reg)
        else $error("row fill without scroll");

endmodule

FILE: tb/text_console_writer_test.sv
`timescale 1ns / 100ps

module text_console_writer_test;

    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int ITEMS_PER_PHASE = 375;

    typedef struct {
        logic [CPOS_W-1:0] cursor_pos;
        logic [CHAR_W-1:0] read_char;
        logic [ATTR_W-1:0] read_attr;
        logic              scrolled;
    } console_out_t;

    class console_mirror;
        logic [CELL_W-1:0] cells [CELLS];
        int                row;
        int                col;
        int                cursor;
        logic [ATTR_W-1:0] attr;
        console_out_t      due_outputs [$];
        int                faults;

        function new();
            int i;
            for (i = 0; i < CELLS; i++)
                cells[i] = {BLANK_ATTR, SPACE_CHAR};
            row = 0;
            col = 0;
            cursor = 0;
            attr = BLANK_ATTR;
            faults = 0;
        endfunction

        function void apply_command(logic cmd, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
            console_out_t o;
            int i;
            o.read_char = '0;
            o.read_attr = '0;
            o.scrolled = 1'b0;
            if (cmd == CMD_READ)
            begin
                if (idx < CELLS)
                begin
                    o.read_char = cells[idx][CHAR_W-1:0];
                    o.read_attr = cells[idx][CELL_W-1:CHAR_W];
                end
            end
            else if (ch == NEWLINE_CHAR)
            begin
                if (row < ROWS)
                    row++;
                col = 0;
            end
            else
            begin
                if (col >= COLS)
                begin
                    col = 0;
                    if (row < ROWS)
                        row++;
                end
                if (row >= ROWS)
                begin
                    for (i = 0; i < CELLS - COLS; i++)
                        cells[i] = cells[i + COLS];
                    for (i = CELLS - COLS; i < CELLS; i++)
                        cells[i] = {attr, SPACE_CHAR};
                    row = ROWS - 1;
                    o.scrolled = 1'b1;
                end
                cells[row * COLS + col] = {attr, ch};
                col++;
                cursor = row * COLS + col;
            end
            o.cursor_pos = CPOS_W'(cursor);
            due_outputs.push_back(o);
        endfunction

        function void match_output(logic [CPOS_W-1:0] cpos, logic [CHAR_W-1:0] rch,
                                   logic [ATTR_W-1:0] rattr, logic scr);
            console_out_t e;
            if (due_outputs.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display({"unexpected item: cursor_pos %0d read_char %h",
                              " read_attr %h scrolled %b"},
                             cpos, rch, rattr, scr);
                return;
            end
            e = due_outputs.pop_front();
            if (cpos !== e.cursor_pos || rch !== e.read_char || rattr !== e.read_attr ||
                scr !== e.scrolled)
            begin
                faults++;
                if (faults <= 10)
                    $display({"mismatch: cursor_pos %0d/%0d read_char %h/%h",
                              " read_attr %h/%h scrolled %b/%b (exp/got)"},
                             e.cursor_pos, cpos, e.read_char, rch, e.read_attr, rattr,
                             e.scrolled, scr);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               command = CMD_PUT;
    logic [CHAR_W-1:0]  char_code = '0;
    logic [IDX_W-1:0]   cell_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    logic [CPOS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0]  read_char;
    logic [ATTR_W-1:0]  read_attr;
    logic               scrolled;

    console_mirror board = new();
    int cycle_count = 0;
    int sent_count = 0;
    int tx_calm = 0;
    int rx_calm = 0;

    text_console_writer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_pos (cursor_pos),
        .read_char  (read_char),
        .read_attr  (read_attr),
        .scrolled   (scrolled)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.match_output(cursor_pos, read_char, read_attr, scrolled);
    end

    function automatic int pick_gap(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_glyph();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (c == NEWLINE_CHAR)
            c = CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            n = pick_gap(rx_calm);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(rst_n && out_valid))
                @(posedge clk);
        end
    end

    task automatic send_item(logic cmd, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        char_code <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.apply_command(cmd, ch, idx);
        sent_count++;
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_item(CMD_PUT, ch, IDX_W'($urandom));
    endtask

    task automatic read_cell(logic [IDX_W-1:0] idx);
        send_item(CMD_READ, CHAR_W'($urandom), idx);
    endtask

    task automatic fill_row();
        int n;
        n = (board.col >= COLS) ? 0 : COLS - board.col;
        repeat (n) put_char(rand_glyph());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.due_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attr(logic [ATTR_W-1:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TEXT_ATTR, 2'b00};
        pwdata <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.attr = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[ATTR_W-1:0] !== v)
        begin
            board.faults++;
            if (board.faults <= 10)
                $display("mismatch: text_attr read back %h, expected %h",
                         prdata[ATTR_W-1:0], v);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_scenario();
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            n = $urandom_range(1, COLS + 2);
            for (i = 0; i < n; i++)
                put_char(rand_glyph());
            if ($urandom_range(0, 1))
                put_char(NEWLINE_CHAR);
        end
        else if (kind < 40)
        begin
            n = $urandom_range(1, ROWS + 5);
            repeat (n) put_char(NEWLINE_CHAR);
            put_char(rand_glyph());
        end
        else if (kind < 65)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    read_cell(IDX_W'($urandom));
                else
                    read_cell(IDX_W'($urandom_range(0, CELLS - 1)));
            end
        end
        else if (kind < 80)
        begin
            fill_row();
            put_char(rand_glyph());
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(1'($urandom), CHAR_W'($urandom), IDX_W'($urandom));
        end
        else
        begin
            read_cell(IDX_W'(board.cursor > 0 ? board.cursor - 1 : 0));
            read_cell(IDX_W'((board.row < ROWS ? board.row : ROWS - 1) * COLS));
            read_cell(IDX_W'(CELLS - 1));
        end
    endtask

    initial
    begin
        int ph;
        int start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_attr(8'h00);

        read_cell(0);
        read_cell(IDX_W'(CELLS - 1));
        read_cell(IDX_W'(CELLS));
        read_cell({IDX_W{1'b1}});
        put_char(8'h00);
        put_char(8'hFF);
        put_char(NEWLINE_CHAR);
        put_char(NEWLINE_CHAR);
        put_char(8'h7E);
        read_cell(0);
        read_cell(1);
        read_cell(IDX_W'(2 * COLS));
        read_cell(IDX_W'(2 * COLS + 1));

        wait_drained();
        write_attr(8'hFF);
        put_char(SPACE_CHAR);
        put_char(8'h80);
        send_item(CMD_READ, 8'hFF, IDX_W'(2 * COLS + 1));
        send_item(CMD_READ, 8'h00, IDX_W'(2 * COLS + 2));
        send_item(CMD_PUT, 8'h55, {IDX_W{1'b1}});

        // walk down past the bottom, then fill the last row to its end and wrap
        repeat (ROWS + 3) put_char(NEWLINE_CHAR);
        put_char(rand_glyph());
        fill_row();
        read_cell(IDX_W'(CELLS - 1));
        put_char(rand_glyph());
        read_cell(IDX_W'(CELLS - COLS));
        read_cell(IDX_W'(CELLS - COLS - 1));

        for (ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            case (ph)
                0: write_attr(ATTR_W'($urandom));
                1: write_attr(8'hFF);
                2: write_attr(8'h00);
                default: write_attr(ATTR_W'($urandom));
            endcase
            start = sent_count;
            while (sent_count < start + ITEMS_PER_PHASE)
                run_scenario();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.faults == 0 && board.due_outputs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
tb/text_console_writer_test.sv
